FILE: hw/rtl/mte_pkg.sv
// Shared types, constants and codes for the MIDI track event encoder.
package mte_pkg;

  // Event kinds
  typedef enum logic [3:0] {
    OP_NOTEOFF      = 4'd0,
    OP_NOTEON       = 4'd1,
    OP_POLYTOUCH    = 4'd2,
    OP_CONTROL      = 4'd3,
    OP_PROGRAM      = 4'd4,
    OP_CHANPRESSURE = 4'd5,
    OP_BEND         = 4'd6,
    OP_SEQNUM       = 4'd7,
    OP_TEMPO        = 4'd8,
    OP_SMPTE        = 4'd9,
    OP_TIMESIG      = 4'd10,
    OP_KEYSIG       = 4'd11,
    OP_ENDTRACK     = 4'd12
  } op_t;

  // Channel status high nibbles
  localparam logic [3:0] ST_NOTEOFF      = 4'h8;
  localparam logic [3:0] ST_NOTEON       = 4'h9;
  localparam logic [3:0] ST_POLYTOUCH    = 4'hA;
  localparam logic [3:0] ST_CONTROL      = 4'hB;
  localparam logic [3:0] ST_PROGRAM      = 4'hC;
  localparam logic [3:0] ST_CHANPRESSURE = 4'hD;
  localparam logic [3:0] ST_BEND         = 4'hE;

  // Meta event bytes
  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] META_SEQNUM  = 8'h00;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_SMPTE   = 8'h54;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_KEYSIG  = 8'h59;
  localparam logic [7:0] META_EOT     = 8'h2F;

  localparam logic [7:0] LEN_SEQNUM  = 8'h02;
  localparam logic [7:0] LEN_TEMPO   = 8'h03;
  localparam logic [7:0] LEN_SMPTE   = 8'h05;
  localparam logic [7:0] LEN_TIMESIG = 8'h04;
  localparam logic [7:0] LEN_KEYSIG  = 8'h02;
  localparam logic [7:0] LEN_EOT     = 8'h00;

  // Byte counts
  localparam int VLQ_BYTES = 4;
  localparam int EV_BYTES  = 8;
  localparam int MAX_BYTES = VLQ_BYTES + EV_BYTES;
  localparam int VLQ_LEN_W = $clog2(VLQ_BYTES + 1);
  localparam int EV_LEN_W  = $clog2(EV_BYTES + 1);
  localparam int EV_IDX_W  = $clog2(EV_BYTES);
  localparam int VLQ_IDX_W = $clog2(VLQ_BYTES);
  localparam int IDX_W     = $clog2(MAX_BYTES);

  // Request queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One classified event: delta bytes then event bytes, each left-justified
  typedef struct packed {
    logic [VLQ_BYTES-1:0][7:0] vlq;
    logic [VLQ_LEN_W-1:0]      vlq_len;
    logic [EV_BYTES-1:0][7:0]  ev;
    logic [EV_LEN_W-1:0]       ev_len;
  } evt_desc_t;

endpackage

FILE: hw/rtl/mte_front.sv
// Front end: takes requests, encodes the delta and classifies the event.
module mte_front (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3:0]              in_op,
  input  logic [31:0]             in_delta_ticks,
  input  logic [3:0]              in_channel,
  input  logic [7:0]              in_arg_a,
  input  logic [7:0]              in_arg_b,
  input  logic [7:0]              in_arg_c,
  input  logic [7:0]              in_arg_d,
  input  logic [7:0]              in_arg_e,
  input  logic signed [13:0]      in_bend_value,
  input  logic [23:0]             in_tempo_us,
  output logic                    push,
  output mte_pkg::evt_desc_t      push_desc,
  input  logic                    q_ready
);

  logic [27:0] dsat;
  logic [6:0]  g3, g2, g1, g0;
  logic        op_ok;
  logic [13:0] bend_u;

  // Saturate at 0x0FFFFFFF
  assign dsat = (|in_delta_ticks[31:28]) ? 28'hFFF_FFFF : in_delta_ticks[27:0];
  assign g3 = dsat[27:21];
  assign g2 = dsat[20:14];
  assign g1 = dsat[13:7];
  assign g0 = dsat[6:0];

  // +0x2000 mod 2^14 flips the top bit
  assign bend_u = {~in_bend_value[13], in_bend_value[12:0]};

  always_comb begin
    push_desc.vlq     = '0;
    push_desc.vlq_len = '0;
    if (g3 != 7'd0) begin
      push_desc.vlq[0]  = {1'b1, g3};
      push_desc.vlq[1]  = {1'b1, g2};
      push_desc.vlq[2]  = {1'b1, g1};
      push_desc.vlq[3]  = {1'b0, g0};
      push_desc.vlq_len = mte_pkg::VLQ_LEN_W'(4);
    end else if (g2 != 7'd0) begin
      push_desc.vlq[0]  = {1'b1, g2};
      push_desc.vlq[1]  = {1'b1, g1};
      push_desc.vlq[2]  = {1'b0, g0};
      push_desc.vlq_len = mte_pkg::VLQ_LEN_W'(3);
    end else if (g1 != 7'd0) begin
      push_desc.vlq[0]  = {1'b1, g1};
      push_desc.vlq[1]  = {1'b0, g0};
      push_desc.vlq_len = mte_pkg::VLQ_LEN_W'(2);
    end else begin
      push_desc.vlq[0]  = {1'b0, g0};
      push_desc.vlq_len = mte_pkg::VLQ_LEN_W'(1);
    end

    push_desc.ev     = '0;
    push_desc.ev_len = '0;
    op_ok            = 1'b1;
    case (mte_pkg::op_t'(in_op))
      mte_pkg::OP_NOTEOFF: begin
        push_desc.ev[0]  = {mte_pkg::ST_NOTEOFF, in_channel};
        push_desc.ev[1]  = in_arg_a;
        push_desc.ev[2]  = 8'h00;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(3);
      end
      mte_pkg::OP_NOTEON: begin
        push_desc.ev[0]  = {mte_pkg::ST_NOTEON, in_channel};
        push_desc.ev[1]  = in_arg_a;
        push_desc.ev[2]  = in_arg_b;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(3);
      end
      mte_pkg::OP_POLYTOUCH: begin
        push_desc.ev[0]  = {mte_pkg::ST_POLYTOUCH, in_channel};
        push_desc.ev[1]  = in_arg_a;
        push_desc.ev[2]  = in_arg_b;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(3);
      end
      mte_pkg::OP_CONTROL: begin
        push_desc.ev[0]  = {mte_pkg::ST_CONTROL, in_channel};
        push_desc.ev[1]  = in_arg_a;
        push_desc.ev[2]  = in_arg_b;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(3);
      end
      mte_pkg::OP_PROGRAM: begin
        push_desc.ev[0]  = {mte_pkg::ST_PROGRAM, in_channel};
        push_desc.ev[1]  = in_arg_a;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(2);
      end
      mte_pkg::OP_CHANPRESSURE: begin
        push_desc.ev[0]  = {mte_pkg::ST_CHANPRESSURE, in_channel};
        push_desc.ev[1]  = in_arg_a;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(2);
      end
      mte_pkg::OP_BEND: begin
        push_desc.ev[0]  = {mte_pkg::ST_BEND, in_channel};
        push_desc.ev[1]  = {1'b0, bend_u[6:0]};
        push_desc.ev[2]  = {1'b0, bend_u[13:7]};
        push_desc.ev_len = mte_pkg::EV_LEN_W'(3);
      end
      mte_pkg::OP_SEQNUM: begin
        push_desc.ev[0]  = mte_pkg::META_STATUS;
        push_desc.ev[1]  = mte_pkg::META_SEQNUM;
        push_desc.ev[2]  = mte_pkg::LEN_SEQNUM;
        push_desc.ev[3]  = in_arg_a;
        push_desc.ev[4]  = in_arg_b;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(5);
      end
      mte_pkg::OP_TEMPO: begin
        push_desc.ev[0]  = mte_pkg::META_STATUS;
        push_desc.ev[1]  = mte_pkg::META_TEMPO;
        push_desc.ev[2]  = mte_pkg::LEN_TEMPO;
        push_desc.ev[3]  = in_tempo_us[23:16];
        push_desc.ev[4]  = in_tempo_us[15:8];
        push_desc.ev[5]  = in_tempo_us[7:0];
        push_desc.ev_len = mte_pkg::EV_LEN_W'(6);
      end
      mte_pkg::OP_SMPTE: begin
        push_desc.ev[0]  = mte_pkg::META_STATUS;
        push_desc.ev[1]  = mte_pkg::META_SMPTE;
        push_desc.ev[2]  = mte_pkg::LEN_SMPTE;
        push_desc.ev[3]  = in_arg_a;
        push_desc.ev[4]  = in_arg_b;
        push_desc.ev[5]  = in_arg_c;
        push_desc.ev[6]  = in_arg_d;
        push_desc.ev[7]  = in_arg_e;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(8);
      end
      mte_pkg::OP_TIMESIG: begin
        push_desc.ev[0]  = mte_pkg::META_STATUS;
        push_desc.ev[1]  = mte_pkg::META_TIMESIG;
        push_desc.ev[2]  = mte_pkg::LEN_TIMESIG;
        push_desc.ev[3]  = in_arg_a;
        push_desc.ev[4]  = in_arg_b;
        push_desc.ev[5]  = in_arg_c;
        push_desc.ev[6]  = in_arg_d;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(7);
      end
      mte_pkg::OP_KEYSIG: begin
        push_desc.ev[0]  = mte_pkg::META_STATUS;
        push_desc.ev[1]  = mte_pkg::META_KEYSIG;
        push_desc.ev[2]  = mte_pkg::LEN_KEYSIG;
        push_desc.ev[3]  = in_arg_a;
        push_desc.ev[4]  = in_arg_b;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(5);
      end
      mte_pkg::OP_ENDTRACK: begin
        push_desc.ev[0]  = mte_pkg::META_STATUS;
        push_desc.ev[1]  = mte_pkg::META_EOT;
        push_desc.ev[2]  = mte_pkg::LEN_EOT;
        push_desc.ev_len = mte_pkg::EV_LEN_W'(3);
      end
      default: begin
        // unused kinds: accepted and dropped
        op_ok = 1'b0;
      end
    endcase
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && op_ok;

endmodule

FILE: hw/rtl/mte_queue.sv
// Short FIFO of classified events between front and back.
module mte_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mte_pkg::evt_desc_t  push_desc,
  output logic                q_ready,
  input  logic                pop,
  output logic                head_valid,
  output mte_pkg::evt_desc_t  head_desc
);

  mte_pkg::evt_desc_t               entry_r [mte_pkg::QDEPTH];
  logic [mte_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [mte_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [mte_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  localparam logic [mte_pkg::QPTR_W-1:0] PTR_LAST = mte_pkg::QPTR_W'(mte_pkg::QDEPTH - 1);

  assign q_ready    = (count_r != mte_pkg::QCNT_W'(mte_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: hw/rtl/mte_back.sv
// Back end: serializes one queued event a byte per cycle into the output register while out_ready holds.
module mte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  mte_pkg::evt_desc_t  head_desc,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [31:0]         out_track_length
);

  logic [mte_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]               count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                byte_r;
  logic                      last_r;
  logic                      load;
  logic                      in_vlq;
  logic [mte_pkg::IDX_W-1:0] ev_off;
  logic [mte_pkg::IDX_W-1:0] last_idx;
  logic                      is_last;
  logic [7:0]                cur_byte;

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign in_vlq  = idx_r < mte_pkg::IDX_W'(head_desc.vlq_len);
  assign ev_off  = idx_r - mte_pkg::IDX_W'(head_desc.vlq_len);
  assign last_idx = mte_pkg::IDX_W'(head_desc.vlq_len) + mte_pkg::IDX_W'(head_desc.ev_len)
                    - 1'b1;
  assign is_last = (idx_r == last_idx);
  assign cur_byte = in_vlq ? head_desc.vlq[idx_r[mte_pkg::VLQ_IDX_W-1:0]]
                           : head_desc.ev[ev_off[mte_pkg::EV_IDX_W-1:0]];
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? '0 : idx_r + 1'b1;
      count_nxt     = count_r + 32'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_last         = last_r;
  assign out_track_length = count_r;

endmodule

FILE: hw/rtl/midi_track_event_encoder_unit.sv
// Top level of the MIDI track event encoder: front, request queue and back.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   op, delta_ticks, channel, arg_a..e,
//                                             bend_value, tempo_us
//   out_     output     out_valid / out_ready out_byte, out_last, out_track_length
//
// Each encoded request yields 3 to 12 bytes, one per cycle while out_ready holds,
// via the back end's output register; the serializer sets the rate (bytes per event).
// The front encodes a request in the cycle it is accepted and drops unused
// kinds; a two-entry queue lets it take new requests while the back stalls.
// rst_n (synchronous) empties the queue and clears the track byte count.
// A stall on out_ready holds the current byte; input stalls once the queue fills.
module midi_track_event_encoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_op,
  input  logic [31:0]        in_delta_ticks,
  input  logic [3:0]         in_channel,
  input  logic [7:0]         in_arg_a,
  input  logic [7:0]         in_arg_b,
  input  logic [7:0]         in_arg_c,
  input  logic [7:0]         in_arg_d,
  input  logic [7:0]         in_arg_e,
  input  logic signed [13:0] in_bend_value,
  input  logic [23:0]        in_tempo_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic [31:0]        out_track_length
);

  logic               push;
  mte_pkg::evt_desc_t push_desc;
  logic               q_ready;
  logic               pop;
  logic               head_valid;
  mte_pkg::evt_desc_t head_desc;

  // Classify and encode the request
  mte_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_delta_ticks (in_delta_ticks),
    .in_channel     (in_channel),
    .in_arg_a       (in_arg_a),
    .in_arg_b       (in_arg_b),
    .in_arg_c       (in_arg_c),
    .in_arg_d       (in_arg_d),
    .in_arg_e       (in_arg_e),
    .in_bend_value  (in_bend_value),
    .in_tempo_us    (in_tempo_us),
    .push           (push),
    .push_desc      (push_desc),
    .q_ready        (q_ready)
  );

  // Decouples front and back
  mte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // Byte serializer and running track count
  mte_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_desc        (head_desc),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_track_length (out_track_length)
  );

endmodule

FILE: hw/rtl/mte_checker.sv
// Port-level checks for the MIDI track event encoder, bound to the top level.
module mte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [31:0] out_track_length
);

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not empty after reset");

  // A byte inside an event is followed at once by the next, counted one on
  a_event_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_track_length == $past(out_track_length) + 32'd1))
    else $error("gap or count slip inside an event");

  // Output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_byte) && $stable(out_last) && $stable(out_track_length))
    else $error("output payload changed while stalled");

endmodule

bind midi_track_event_encoder_unit mte_checker u_mte_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_last         (out_last),
  .out_track_length (out_track_length)
);
